>>> sv/modexp_pkg.sv
// Package for the modular exponentiation block: field widths and
// configuration register codes. No dependencies.
package modexp_pkg;

   // fixed widths of the stream data and configuration address fields
   localparam int DATA_BITS = 32;
   localparam int CSR_ADDR_BITS = 1;

   typedef logic [CSR_ADDR_BITS-1:0] csr_addr_type;
   typedef logic [DATA_BITS-1:0] data_type;

   // configuration register indexes
   localparam csr_addr_type REG_MODULUS = 1'b0;
   localparam csr_addr_type REG_EXPONENT = 1'b1;

endpackage

>>> sv/modexp_mulmod.sv
// Bit-serial modular multiplier: (a * b) mod m, one multiplier bit per cycle.
// Stand-alone, no package dependencies; used by modular_exponentiation.
module modexp_mulmod #(
   parameter int WORD_BITS = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [WORD_BITS-1:0] op_a,
   input  logic [WORD_BITS-1:0] op_b,
   input  logic [WORD_BITS-1:0] op_m,
   output logic                 done,
   output logic [WORD_BITS-1:0] product
);

   localparam int SUM_BITS = WORD_BITS + 2;
   localparam int CNT_BITS = $clog2(WORD_BITS);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [CNT_BITS-1:0]  cnt_ff, cnt_in;
   logic [WORD_BITS-1:0] acc_ff, acc_in;
   logic [WORD_BITS-1:0] mult_ff, mult_in;

   logic [SUM_BITS-1:0]  sum;
   logic [SUM_BITS-1:0]  mod_one;
   logic [SUM_BITS-1:0]  mod_two;
   logic [SUM_BITS-1:0]  reduced;

   // one step: 2*acc + a*bit, below 3m, then fold back under m
   always_comb begin
      mod_one = {2'b00, op_m};
      mod_two = {1'b0, op_m, 1'b0};
      sum = {1'b0, acc_ff, 1'b0} + (mult_ff[WORD_BITS-1] ? {2'b00, op_a} : '0);
      if (sum >= mod_two) begin
         reduced = sum - mod_two;
      end else if (sum >= mod_one) begin
         reduced = sum - mod_one;
      end else begin
         reduced = sum;
      end
   end

   // step sequencing, multiplier bits consumed msb first
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in = cnt_ff;
      acc_in = acc_ff;
      mult_in = mult_ff;
      if (busy_ff) begin
         acc_in = reduced[WORD_BITS-1:0];
         mult_in = {mult_ff[WORD_BITS-2:0], 1'b0};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_BITS'(WORD_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (start) begin
         busy_in = 1'b1;
         cnt_in = '0;
         acc_in = '0;
         mult_in = op_b;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      acc_ff <= acc_in;
      mult_ff <= mult_in;
   end

   assign done = done_ff;
   assign product = acc_ff;

endmodule

>>> sv/modular_exponentiation.sv
// Modular exponentiation: for each beat, base^exponent mod modulus, with the
// base first reduced mod modulus. Exponent 0 gives 1; a modulus below 2 gives
// 0 and skips the products. One beat is worked at a time. All arithmetic runs
// through a single bit-serial modular multiplier with a registered start. A
// beat needs 1 + WORD_BITS + popcount(exponent) products. The result sits in
// an output register, so the next beat can start once the finished one has
// been stored. Depends on modexp_pkg and modexp_mulmod.
module modular_exponentiation #(
   parameter int WORD_BITS = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   // request stream
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  modexp_pkg::data_type        req_tdata,  // [31:0] base_value
   input  logic                        req_tlast,  // end_of_message
   // response stream
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output modexp_pkg::data_type        rsp_tdata,  // [31:0] power_value
   output logic                        rsp_tlast,  // end_of_message_res
   // configuration writes
   input  logic                        csr_wen,
   input  modexp_pkg::csr_addr_type    csr_addr,
   input  logic [WORD_BITS-1:0]        csr_wdata
);

   import modexp_pkg::*;

   localparam int CNT_BITS = $clog2(WORD_BITS);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_REDUCE = 3'd1;
   localparam logic [2:0] ST_SQUARE = 3'd2;
   localparam logic [2:0] ST_MULT   = 3'd3;
   localparam logic [2:0] ST_OUT    = 3'd4;

   logic [2:0]           state_ff, state_in;
   logic [WORD_BITS-1:0] modulus_ff, modulus_in;
   logic [WORD_BITS-1:0] exponent_ff, exponent_in;
   logic [WORD_BITS-1:0] base_ff, base_in;
   logic [WORD_BITS-1:0] acc_ff, acc_in;
   logic [CNT_BITS-1:0]  bit_ff, bit_in;
   logic                 last_ff, last_in;
   logic                 start_ff, start_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   data_type             rsp_data_ff, rsp_data_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic [WORD_BITS-1:0] mul_a;
   logic [WORD_BITS-1:0] mul_b;
   logic                 mul_done;
   logic [WORD_BITS-1:0] mul_product;
   logic                 out_free;

   // shared modular multiplier
   modexp_mulmod #(
      .WORD_BITS(WORD_BITS)
   ) u_mulmod (
      .clock  (clock),
      .reset  (reset),
      .start  (start_ff),
      .op_a   (mul_a),
      .op_b   (mul_b),
      .op_m   (modulus_ff),
      .done   (mul_done),
      .product(mul_product)
   );

   // operand selection per phase
   always_comb begin
      unique case (state_ff)
         ST_REDUCE: begin
            mul_a = WORD_BITS'(1);
            mul_b = base_ff;
         end
         ST_MULT: begin
            mul_a = acc_ff;
            mul_b = base_ff;
         end
         default: begin
            mul_a = acc_ff;
            mul_b = acc_ff;
         end
      endcase
   end

   // configuration write decode
   always_comb begin
      modulus_in = modulus_ff;
      exponent_in = exponent_ff;
      if (csr_wen) begin
         unique case (csr_addr)
            REG_MODULUS:  modulus_in = csr_wdata;
            REG_EXPONENT: exponent_in = csr_wdata;
            default: ;
         endcase
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign out_free = !rsp_valid_ff || rsp_tready;

   // square-and-multiply sequencer, exponent msb first
   always_comb begin
      state_in = state_ff;
      base_in = base_ff;
      acc_in = acc_ff;
      bit_in = bit_ff;
      last_in = last_ff;
      start_in = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in = rsp_data_ff;
      rsp_last_in = rsp_last_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               base_in = WORD_BITS'(req_tdata);
               last_in = req_tlast;
               if (modulus_ff < WORD_BITS'(2)) begin
                  acc_in = '0;
                  state_in = ST_OUT;
               end else begin
                  start_in = 1'b1;
                  state_in = ST_REDUCE;
               end
            end
         end
         ST_REDUCE: begin
            if (mul_done) begin
               base_in = mul_product;
               acc_in = WORD_BITS'(1);
               bit_in = CNT_BITS'(WORD_BITS - 1);
               start_in = 1'b1;
               state_in = ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            if (mul_done) begin
               acc_in = mul_product;
               if (exponent_ff[bit_ff]) begin
                  start_in = 1'b1;
                  state_in = ST_MULT;
               end else if (bit_ff == '0) begin
                  state_in = ST_OUT;
               end else begin
                  bit_in = bit_ff - 1'b1;
                  start_in = 1'b1;
                  state_in = ST_SQUARE;
               end
            end
         end
         ST_MULT: begin
            if (mul_done) begin
               acc_in = mul_product;
               if (bit_ff == '0) begin
                  state_in = ST_OUT;
               end else begin
                  bit_in = bit_ff - 1'b1;
                  start_in = 1'b1;
                  state_in = ST_SQUARE;
               end
            end
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in = DATA_BITS'(acc_ff);
               rsp_last_in = last_ff;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         modulus_ff <= WORD_BITS'(2);
         exponent_ff <= WORD_BITS'(1);
         start_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         modulus_ff <= modulus_in;
         exponent_ff <= exponent_in;
         start_ff <= start_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      base_ff <= base_in;
      acc_ff <= acc_in;
      bit_ff <= bit_in;
      last_ff <= last_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;
   assign rsp_tlast = rsp_last_ff;

endmodule
